// ===== sv/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int REMAIN_W   = $clog2(NUM_DIGITS + 1);

    // ASCII '0' in the 6-bit character field
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    // Double dabble: a BCD digit of 5 or more gets 3 added before the shift
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = DIGIT_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Control broadcast from the sequencer to every digit cell
    typedef struct packed {
        logic clear;     // new item: zero the digit
        logic convert;   // one double-dabble step
        logic advance;   // pass digits one place toward the output end
    } cell_ctrl_t;

endpackage

// ===== sv/b2da_cell.sv =====
// One BCD digit cell of the double-dabble chain.
module b2da_cell
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic               carry_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adjusted;

    // add-3 correction ahead of the shift
    always_comb
    begin
        if (digit_reg >= DABBLE_LIMIT)
        begin
            adjusted = digit_reg + DABBLE_ADD;
        end
        else
        begin
            adjusted = digit_reg;
        end
    end

    assign carry_out = adjusted[DIGIT_W-1];

    // next digit value
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adjusted[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.advance)
        begin
            digit_next = digit_in;
        end
    end

    // digit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

// ===== sv/b2da_ctrl.sv =====
// Sequencer: input shift register, step counters and output register.
module b2da_ctrl
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit,
    input  logic [DIGIT_W-1:0] top_digit,
    output logic               msb_bit,
    output cell_ctrl_t         cell_ctrl
);

    state_t               state_reg;
    state_t               state_next;
    logic [VALUE_W-1:0]   value_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [REMAIN_W-1:0]  remain_reg;
    logic                 started_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    digit_char_reg;
    logic                 last_digit_reg;

    logic in_accept;
    logic skip;
    logic slot_free;
    logic emit_fire;
    logic last_step;
    logic final_digit;

    assign last_step   = (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1));
    assign final_digit = (remain_reg == REMAIN_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (last_step)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire && final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        skip      = 1'b0;
        emit_fire = 1'b0;
        slot_free = !out_valid_reg || out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CONV:
            begin
                in_ready = 1'b0;
            end
            ST_EMIT:
            begin
                // drop leading zeros, always keep the final digit
                skip      = !started_reg && (top_digit == '0) && !final_digit;
                emit_fire = !skip && slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_accept         = in_valid && in_ready;
    assign cell_ctrl.clear   = in_accept;
    assign cell_ctrl.convert = (state_reg == ST_CONV);
    assign cell_ctrl.advance = skip || emit_fire;
    assign msb_bit           = value_reg[VALUE_W-1];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                bit_cnt_reg <= '0;
                remain_reg  <= REMAIN_W'(NUM_DIGITS);
                started_reg <= 1'b0;
            end
            else
            begin
                if (cell_ctrl.convert)
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
                if (cell_ctrl.advance)
                begin
                    remain_reg <= remain_reg - 1'b1;
                end
                if (emit_fire)
                begin
                    started_reg <= 1'b1;
                end
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            value_reg <= value;
        end
        else if (cell_ctrl.convert)
        begin
            value_reg <= {value_reg[VALUE_W-2:0], 1'b0};
        end
        if (emit_fire)
        begin
            digit_char_reg <= ASCII_ZERO + CHAR_W'(top_digit);
            last_digit_reg <= final_digit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

    // a digit only leaves once conversion is done
    a_emit_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (state_reg == ST_EMIT) && (remain_reg != '0))
        else $error("digit emitted outside emit phase");

    // emission always ends on a flagged digit
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && final_digit) |=> (state_reg == ST_IDLE) && last_digit_reg)
        else $error("last digit not flagged at end of item");

    // conversion runs exactly one word of shift steps
    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CONV) && last_step) |=> (state_reg == ST_EMIT)
            && (remain_reg == REMAIN_W'(NUM_DIGITS)))
        else $error("conversion length wrong");

endmodule

// ===== sv/binary_to_decimal_ascii.sv =====
// Top level: 32-bit binary to decimal ASCII converter built on a chain of BCD cells.
//
//   channel | signals                        | direction | width
//   --------+--------------------------------+-----------+---------------
//   in      | in_valid, in_ready, value      | to block  | 32
//   out     | out_valid, out_ready,          | from block| 6 + 1
//           | digit_char, last_digit         |           |
//
// An item is accepted, then its 32 bits are shifted by double dabble through the ten
// digit cells (one input bit per cycle), then the chain is drained: leading zeros are
// dropped, and digits leave one per cycle while the output is not stalled.
// Reset clears the sequencer state and counters, the digit cells and output valid.
// The next item is taken as soon as the last digit sits in the output register.
module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    cell_ctrl_t         cell_ctrl;
    logic               msb_bit;
    logic [NUM_DIGITS:0] carry;
    logic [DIGIT_W-1:0] digits [NUM_DIGITS];
    logic [DIGIT_W-1:0] digit_feed [NUM_DIGITS];

    // sequencer
    b2da_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit),
        .top_digit  (digits[NUM_DIGITS-1]),
        .msb_bit    (msb_bit),
        .cell_ctrl  (cell_ctrl)
    );

    assign carry[0] = msb_bit;

    // digit chain, cell 0 is least significant
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign digit_feed[i] = '0;
        end
        else
        begin : g_rest
            assign digit_feed[i] = digits[i-1];
        end

        b2da_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .carry_in  (carry[i]),
            .digit_in  (digit_feed[i]),
            .carry_out (carry[i+1]),
            .digit     (digits[i])
        );
    end

    // ten digits always hold a 32-bit value
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.convert |-> !carry[NUM_DIGITS])
        else $error("digit chain overflow");

    // every character is a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
        else $error("character out of digit range");

    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");

endmodule
